// ===== hw/rtl/hsu_pkg.sv =====
// ----------------------------------------------------------------------------
// hsu_pkg
// Shared types, constants and the halfband tap table for the stereo 2x
// upsampler.
// ----------------------------------------------------------------------------
package hsu_pkg;

    // sizes
    localparam int HISTORY_DEPTH_DEF = 32;
    localparam int SAMPLE_W          = 16;
    localparam int TAP_W             = 31;
    localparam int TAP_IDX_W         = 4;
    localparam int PAIR_W            = SAMPLE_W + 1;
    localparam int PROD_W            = TAP_W + PAIR_W;
    localparam int ACC_W             = 50;
    localparam int Q_SHIFT           = 30;
    localparam int RES_W             = ACC_W - Q_SHIFT;
    localparam int HALF_TAPS         = 15;
    localparam int NUM_TAPS          = 2 * HALF_TAPS + 1;
    localparam int CLIP_W            = 32;
    localparam int CNT_W             = 6;

    // sequencer steps
    localparam logic [CNT_W-1:0] MAC_OPS   = CNT_W'(2 * HALF_TAPS);
    localparam logic [CNT_W-1:0] PT_ISSUE  = CNT_W'(2 * HALF_TAPS);
    localparam logic [CNT_W-1:0] RND_LEFT  = CNT_W'(2 * HALF_TAPS + 2);
    localparam logic [CNT_W-1:0] RND_RIGHT = CNT_W'(2 * HALF_TAPS + 3);

    // channel select codes
    localparam logic CHAN_LEFT  = 1'b0;
    localparam logic CHAN_RIGHT = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic                       is_last;
        logic [CLIP_W-1:0]          clip_total;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_MID,
        ST_LAST
    } seq_state_t;

    typedef struct packed {
        logic                 clear;
        logic                 valid;
        logic                 chan;
        logic [TAP_IDX_W-1:0] tap_idx;
    } mac_ctrl_t;

    // Q30 halfband taps, index 1..15; any other index returns zero
    function automatic logic signed [TAP_W-1:0] tap_coef(input logic [TAP_IDX_W-1:0] idx);
        logic signed [TAP_W-1:0] c;
        unique case (idx)
            4'd1:    c =  31'sh001596F;
            4'd2:    c = -31'sh0060A93;
            4'd3:    c =  31'sh00F9AE1;
            4'd4:    c = -31'sh02068AB;
            4'd5:    c =  31'sh03BBE98;
            4'd6:    c = -31'sh065EA02;
            4'd7:    c =  31'sh0A46788;
            4'd8:    c = -31'sh0FE513A;
            4'd9:    c =  31'sh17D6A04;
            4'd10:   c = -31'sh2309CFC;
            4'd11:   c =  31'sh3323504;
            4'd12:   c = -31'sh4B92B98;
            4'd13:   c =  31'sh7546848;
            4'd14:   c = -31'shD133810;
            4'd15:   c =  31'sh28928D80;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/hsu_history.sv =====
// ----------------------------------------------------------------------------
// hsu_history
// Stereo sample history ring: one write port, two registered read ports.
// Entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module hsu_history #(
    parameter int HISTORY_DEPTH = hsu_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             wr_en,
    input  logic [$clog2(HISTORY_DEPTH)-1:0] wr_addr,
    input  hsu_pkg::in_item_t                wr_data,
    input  logic [$clog2(HISTORY_DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(HISTORY_DEPTH)-1:0] rd_addr_b,
    output hsu_pkg::in_item_t                rd_data_a,
    output hsu_pkg::in_item_t                rd_data_b
);

    hsu_pkg::in_item_t          mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0]   valid_reg;
    hsu_pkg::in_item_t          rd_a_reg;
    hsu_pkg::in_item_t          rd_b_reg;
    logic                       rd_a_vld_reg;
    logic                       rd_b_vld_reg;

    // per-entry written flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // sample store
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered reads
    always_ff @(posedge aclk) begin
        rd_a_reg     <= mem[rd_addr_a];
        rd_b_reg     <= mem[rd_addr_b];
        rd_a_vld_reg <= valid_reg[rd_addr_a];
        rd_b_vld_reg <= valid_reg[rd_addr_b];
    end

    // unwritten entries read as zero
    assign rd_data_a = rd_a_vld_reg ? rd_a_reg : '0;
    assign rd_data_b = rd_b_vld_reg ? rd_b_reg : '0;

endmodule

// ===== hw/rtl/hsu_mac.sv =====
// ----------------------------------------------------------------------------
// hsu_mac
// Shared multiply-accumulate unit: adds a symmetric sample pair, multiplies
// by one tap and accumulates into the left or right channel sum.
// ----------------------------------------------------------------------------
module hsu_mac (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  hsu_pkg::mac_ctrl_t                    ctrl,
    input  hsu_pkg::in_item_t                     rd_data_a,
    input  hsu_pkg::in_item_t                     rd_data_b,
    output logic signed [hsu_pkg::ACC_W-1:0]      acc_left,
    output logic signed [hsu_pkg::ACC_W-1:0]      acc_right
);

    logic signed [hsu_pkg::SAMPLE_W-1:0] x_a;
    logic signed [hsu_pkg::SAMPLE_W-1:0] x_b;
    logic signed [hsu_pkg::PAIR_W-1:0]   pair;
    logic signed [hsu_pkg::TAP_W-1:0]    tap;
    logic signed [hsu_pkg::PROD_W-1:0]   prod_next;
    logic signed [hsu_pkg::PROD_W-1:0]   prod_reg;
    logic                                prod_vld_reg;
    logic                                prod_chan_reg;
    logic signed [hsu_pkg::ACC_W-1:0]    acc_left_reg;
    logic signed [hsu_pkg::ACC_W-1:0]    acc_right_reg;
    logic signed [hsu_pkg::ACC_W-1:0]    acc_sel;
    logic signed [hsu_pkg::ACC_W-1:0]    acc_next;

    // pair add and multiply
    always_comb begin
        x_a       = (ctrl.chan == hsu_pkg::CHAN_RIGHT) ? rd_data_a.right_sample
                                                       : rd_data_a.left_sample;
        x_b       = (ctrl.chan == hsu_pkg::CHAN_RIGHT) ? rd_data_b.right_sample
                                                       : rd_data_b.left_sample;
        pair      = hsu_pkg::PAIR_W'(x_a) + hsu_pkg::PAIR_W'(x_b);
        tap       = hsu_pkg::tap_coef(ctrl.tap_idx);
        prod_next = hsu_pkg::PROD_W'(tap) * hsu_pkg::PROD_W'(pair);
    end

    // product stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= ctrl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg      <= prod_next;
        prod_chan_reg <= ctrl.chan;
    end

    // accumulate
    always_comb begin
        acc_sel  = (prod_chan_reg == hsu_pkg::CHAN_RIGHT) ? acc_right_reg : acc_left_reg;
        acc_next = acc_sel + hsu_pkg::ACC_W'(prod_reg);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            acc_left_reg  <= '0;
            acc_right_reg <= '0;
        end else if (prod_vld_reg) begin
            if (prod_chan_reg == hsu_pkg::CHAN_RIGHT) begin
                acc_right_reg <= acc_next;
            end else begin
                acc_left_reg <= acc_next;
            end
        end
    end

    assign acc_left  = acc_left_reg;
    assign acc_right = acc_right_reg;

endmodule

// ===== hw/rtl/hsu_round.sv =====
// ----------------------------------------------------------------------------
// hsu_round
// Scales a Q30 sum to an integer, rounding half away from zero, and
// saturates it to a 16-bit sample with a clip flag.
// ----------------------------------------------------------------------------
module hsu_round (
    input  logic signed [hsu_pkg::ACC_W-1:0]    acc,
    output logic signed [hsu_pkg::SAMPLE_W-1:0] sample,
    output logic                                clip
);

    localparam logic signed [hsu_pkg::ACC_W-1:0] RND_HALF =
        hsu_pkg::ACC_W'(64'sd1 <<< (hsu_pkg::Q_SHIFT - 1));
    localparam logic signed [hsu_pkg::ACC_W-1:0] RND_HALF_M1 =
        hsu_pkg::ACC_W'((64'sd1 <<< (hsu_pkg::Q_SHIFT - 1)) - 64'sd1);
    localparam logic signed [hsu_pkg::RES_W-1:0] SAT_MAX =
        hsu_pkg::RES_W'((64'sd1 <<< (hsu_pkg::SAMPLE_W - 1)) - 64'sd1);
    localparam logic signed [hsu_pkg::RES_W-1:0] SAT_MIN =
        hsu_pkg::RES_W'(-(64'sd1 <<< (hsu_pkg::SAMPLE_W - 1)));

    logic signed [hsu_pkg::ACC_W-1:0] biased;
    logic signed [hsu_pkg::RES_W-1:0] scaled;

    // negative sums take half minus one, giving round half away from zero
    always_comb begin
        biased = acc + (acc[hsu_pkg::ACC_W-1] ? RND_HALF_M1 : RND_HALF);
        scaled = biased[hsu_pkg::ACC_W-1:hsu_pkg::Q_SHIFT];
        if (scaled > SAT_MAX) begin
            sample = SAT_MAX[hsu_pkg::SAMPLE_W-1:0];
            clip   = 1'b1;
        end else if (scaled < SAT_MIN) begin
            sample = SAT_MIN[hsu_pkg::SAMPLE_W-1:0];
            clip   = 1'b1;
        end else begin
            sample = scaled[hsu_pkg::SAMPLE_W-1:0];
            clip   = 1'b0;
        end
    end

endmodule

// ===== hw/rtl/halfband_stereo_upsampler_2x.sv =====
// ----------------------------------------------------------------------------
// halfband_stereo_upsampler_2x
// Stereo 2x interpolator on a 31-tap halfband filter with one shared MAC.
// ----------------------------------------------------------------------------
// Each input transaction carries one stereo frame and produces two output
// transactions: first the interpolated midpoint (is_last = 0), then the frame
// delayed by 15 samples (is_last = 1); clip_total is the same in both. A frame
// occupies the block through its acceptance, 34 sequencer steps and two output
// transactions, plus any output stall. The sequencer time is set
// by the single 31x17 multiplier, which runs 30 operations (15 tap pairs for
// each channel) through a read, multiply, accumulate pipeline, followed by
// two rounding steps, one per channel. s_ready is high only while the block
// is idle. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module halfband_stereo_upsampler_2x #(
    parameter int HISTORY_DEPTH = hsu_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hsu_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hsu_pkg::out_item_t  m_data
);

    localparam int AW = $clog2(HISTORY_DEPTH);

    hsu_pkg::seq_state_t                  state_reg;
    hsu_pkg::seq_state_t                  state_next;
    logic [hsu_pkg::CNT_W-1:0]            cnt_reg;
    logic [hsu_pkg::CNT_W-1:0]            cnt_next;
    logic [AW-1:0]                        wp_reg;
    logic [AW-1:0]                        wp_next;
    hsu_pkg::mac_ctrl_t                   ctrl_reg;
    hsu_pkg::mac_ctrl_t                   ctrl_next;
    logic                                 pt_reg;
    logic                                 pt_next;
    hsu_pkg::in_item_t                    pass_reg;
    logic signed [hsu_pkg::SAMPLE_W-1:0]  mid_left_reg;
    logic signed [hsu_pkg::SAMPLE_W-1:0]  mid_right_reg;
    logic [hsu_pkg::CLIP_W-1:0]           clip_reg;
    logic [hsu_pkg::CLIP_W-1:0]           clip_next;

    logic                                 s_accept;
    logic [hsu_pkg::TAP_IDX_W-1:0]        k_iss;
    logic [AW-1:0]                        rd_addr_a;
    logic [AW-1:0]                        rd_addr_b;
    hsu_pkg::in_item_t                    rd_data_a;
    hsu_pkg::in_item_t                    rd_data_b;
    logic signed [hsu_pkg::ACC_W-1:0]     acc_left;
    logic signed [hsu_pkg::ACC_W-1:0]     acc_right;
    logic signed [hsu_pkg::ACC_W-1:0]     rnd_acc;
    logic signed [hsu_pkg::SAMPLE_W-1:0]  rnd_sample;
    logic                                 rnd_clip;
    logic                                 rnd_left_step;
    logic                                 rnd_right_step;

    assign s_accept = s_valid && s_ready;

    // sequencer: next state, step counter and issue controls
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        wp_next        = wp_reg;
        s_ready        = 1'b0;
        m_valid        = 1'b0;
        k_iss          = cnt_reg[hsu_pkg::TAP_IDX_W:1] + hsu_pkg::TAP_IDX_W'(1);
        rnd_left_step  = 1'b0;
        rnd_right_step = 1'b0;
        ctrl_next      = '0;
        pt_next        = 1'b0;

        unique case (state_reg)
            hsu_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next      = hsu_pkg::ST_RUN;
                    cnt_next        = '0;
                    wp_next         = wp_reg + AW'(1);
                    ctrl_next.clear = 1'b1;
                end
            end
            hsu_pkg::ST_RUN: begin
                cnt_next          = cnt_reg + hsu_pkg::CNT_W'(1);
                ctrl_next.valid   = (cnt_reg < hsu_pkg::MAC_OPS);
                ctrl_next.chan    = cnt_reg[0];
                ctrl_next.tap_idx = k_iss;
                pt_next           = (cnt_reg == hsu_pkg::PT_ISSUE);
                rnd_left_step     = (cnt_reg == hsu_pkg::RND_LEFT);
                rnd_right_step    = (cnt_reg == hsu_pkg::RND_RIGHT);
                if (cnt_reg == hsu_pkg::RND_RIGHT) begin
                    state_next = hsu_pkg::ST_MID;
                end
            end
            hsu_pkg::ST_MID: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = hsu_pkg::ST_LAST;
                end
            end
            hsu_pkg::ST_LAST: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = hsu_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hsu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hsu_pkg::ST_IDLE;
            cnt_reg   <= '0;
            wp_reg    <= '0;
            ctrl_reg  <= '0;
            pt_reg    <= 1'b0;
            clip_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            wp_reg    <= wp_next;
            ctrl_reg  <= ctrl_next;
            pt_reg    <= pt_next;
            clip_reg  <= clip_next;
        end
    end

    // symmetric read addresses; the pass-through tap reuses port a
    always_comb begin
        if (state_reg == hsu_pkg::ST_RUN && cnt_reg == hsu_pkg::PT_ISSUE) begin
            rd_addr_a = wp_reg - AW'(hsu_pkg::HALF_TAPS);
        end else begin
            rd_addr_a = wp_reg - AW'(k_iss);
        end
        rd_addr_b = wp_reg - AW'(hsu_pkg::NUM_TAPS) + AW'(k_iss);
    end

    hsu_history #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_history (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (s_accept),
        .wr_addr   (wp_next),
        .wr_data   (s_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    hsu_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl_reg),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .acc_left  (acc_left),
        .acc_right (acc_right)
    );

    // one rounding unit, left channel first
    assign rnd_acc = rnd_right_step ? acc_right : acc_left;

    hsu_round u_round (
        .acc    (rnd_acc),
        .sample (rnd_sample),
        .clip   (rnd_clip)
    );

    // saturating clip counter
    always_comb begin
        clip_next = clip_reg;
        if ((rnd_left_step || rnd_right_step) && rnd_clip && (clip_reg != '1)) begin
            clip_next = clip_reg + hsu_pkg::CLIP_W'(1);
        end
    end

    // result registers
    always_ff @(posedge aclk) begin
        if (pt_reg) begin
            pass_reg <= rd_data_a;
        end
        if (rnd_left_step) begin
            mid_left_reg <= rnd_sample;
        end
        if (rnd_right_step) begin
            mid_right_reg <= rnd_sample;
        end
    end

    // output transaction payload
    always_comb begin
        if (state_reg == hsu_pkg::ST_LAST) begin
            m_data.left_out  = pass_reg.left_sample;
            m_data.right_out = pass_reg.right_sample;
            m_data.is_last   = 1'b1;
        end else begin
            m_data.left_out  = mid_left_reg;
            m_data.right_out = mid_right_reg;
            m_data.is_last   = 1'b0;
        end
        m_data.clip_total = clip_reg;
    end

endmodule

// ===== dv/halfband_stereo_upsampler_2x_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// halfband_stereo_upsampler_2x_test
// Self-checking bench for the stereo 2x halfband upsampler.
// ----------------------------------------------------------------------------
// Frames go in over the s_ channel and every output transaction is checked
// field by field against a predictor that keeps its own sample rings, write
// pointer and clip count. Stimulus runs from an impulse and full-scale
// frames, through alternating full-scale runs that drive the midpoint into
// saturation on one or both channels, to a long random mix. Both sides idle
// in random bursts; the sender drains the block once mid-run, and the last
// part runs with no idling at all.
// ----------------------------------------------------------------------------
module halfband_stereo_upsampler_2x_test;

    localparam int SAMPLE_W    = hsu_pkg::SAMPLE_W;
    localparam int HALF_TAPS   = hsu_pkg::HALF_TAPS;
    localparam int NUM_TAPS    = hsu_pkg::NUM_TAPS;
    localparam int Q_SHIFT     = hsu_pkg::Q_SHIFT;
    localparam int CLIP_W      = hsu_pkg::CLIP_W;
    localparam int RING        = hsu_pkg::HISTORY_DEPTH_DEF;
    localparam int PASS_DELAY  = HALF_TAPS;
    localparam int TAIL_CYCLES = 80;
    localparam int MAX_REPORTS = 10;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef enum int {
        MIX_UNIFORM,
        MIX_SLIP,
        MIX_QUIET,
        MIX_EXTREMES,
        MIX_SPARSE
    } mix_mode_t;

    // clock, reset and block ports
    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    hsu_pkg::in_item_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    hsu_pkg::out_item_t m_data;

    // halfband taps in Q30, index 1..15
    longint hb_tap [1:HALF_TAPS] = '{
        64'sh1596F,   -64'sh60A93,   64'shF9AE1,    -64'sh2068AB,  64'sh3BBE98,
        -64'sh65EA02, 64'shA46788,   -64'shFE513A,  64'sh17D6A04,  -64'sh2309CFC,
        64'sh3323504, -64'sh4B92B98, 64'sh7546848,  -64'shD133810, 64'sh28928D80
    };

    // predictor state
    logic signed [SAMPLE_W-1:0] left_ring  [RING];
    logic signed [SAMPLE_W-1:0] right_ring [RING];
    logic [4:0]                 ring_ptr   = '0;
    logic [CLIP_W-1:0]          clip_tally = '0;
    hsu_pkg::out_item_t         expected_upsampled [$];

    // bench bookkeeping
    bit idling_on      = 1'b1;
    int frames_sent    = 0;
    int results_seen   = 0;
    int mismatch_count = 0;
    int tail_frames    = 0;

    halfband_stereo_upsampler_2x u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 100 MHz clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #8_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // exact tap-pair accumulation, rounded half away from zero
    function automatic longint halfband_midpoint(input logic signed [SAMPLE_W-1:0] ring [RING]);
        longint          acc;
        longint          pair;
        longint          rounded;
        longint unsigned mag;
        acc = 0;
        for (int k = 1; k <= HALF_TAPS; k++) begin
            pair = longint'(ring[(int'(ring_ptr) - k) & (RING - 1)])
                 + longint'(ring[(int'(ring_ptr) - (NUM_TAPS - k)) & (RING - 1)]);
            acc += hb_tap[k] * pair;
        end
        mag     = (acc < 0) ? longint'(-acc) : acc;
        mag     = (mag + (64'd1 << (Q_SHIFT - 1))) >> Q_SHIFT;
        rounded = longint'(mag);
        return (acc < 0) ? -rounded : rounded;
    endfunction

    // clamp to 16 bits, counting each clip with a sticky-full counter
    function automatic logic signed [SAMPLE_W-1:0] saturate_and_count(input longint value);
        if (value > longint'(SAMPLE_MAX) || value < longint'(SAMPLE_MIN)) begin
            if (clip_tally != '1)
                clip_tally = clip_tally + CLIP_W'(1);
            return (value > 0) ? SAMPLE_MAX : SAMPLE_MIN;
        end
        return SAMPLE_W'(value);
    endfunction

    // advance the rings and queue the midpoint and pass-through results
    function automatic void predict_upsampled(input hsu_pkg::in_item_t frame);
        hsu_pkg::out_item_t mid;
        hsu_pkg::out_item_t thru;
        ring_ptr             = ring_ptr + 5'(1);
        left_ring[ring_ptr]  = frame.left_sample;
        right_ring[ring_ptr] = frame.right_sample;
        // left is checked for clipping before right
        mid.left_out    = saturate_and_count(halfband_midpoint(left_ring));
        mid.right_out   = saturate_and_count(halfband_midpoint(right_ring));
        mid.is_last     = 1'b0;
        mid.clip_total  = clip_tally;
        thru.left_out   = left_ring[5'(ring_ptr - 5'(PASS_DELAY))];
        thru.right_out  = right_ring[5'(ring_ptr - 5'(PASS_DELAY))];
        thru.is_last    = 1'b1;
        thru.clip_total = clip_tally;
        expected_upsampled.push_back(mid);
        expected_upsampled.push_back(thru);
    endfunction

    // one input transaction, with an optional idle burst afterwards
    task automatic send_frame(input logic signed [SAMPLE_W-1:0] left,
                              input logic signed [SAMPLE_W-1:0] right);
        int gap;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= '{left_sample: left, right_sample: right};
        do @(posedge aclk); while (!s_ready);
        predict_upsampled(s_data);
        frames_sent++;
        if (!idling_on)
            tail_frames++;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // stop sending and wait for every queued result
    task automatic hold_off_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_upsampled.size() != 0)
            @(posedge aclk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] slip_sample(input bit positive);
        int amp;
        amp = int'(SAMPLE_MAX) - $urandom_range(0, 1500);
        return SAMPLE_W'(positive ? amp : -amp);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] extreme_value();
        case ($urandom_range(0, 3))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return 16'sd0;
            default: return -16'sd1;
        endcase
    endfunction

    // near full-scale samples alternating in sign, with a repeated sign every
    // 15 frames so the history lines up with the tap signs and the sum clips
    task automatic send_slip_run(input int frames, input bit drive_left,
                                 input bit drive_right, input bit invert_right);
        bit                         sign;
        int                         pos;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        sign = 1'($urandom_range(0, 1));
        pos  = $urandom_range(0, 14);
        repeat (frames) begin
            pos++;
            if (pos % 15 != 0)
                sign = !sign;
            left  = drive_left  ? slip_sample(sign) : SAMPLE_W'($urandom);
            right = drive_right ? slip_sample(sign ^ invert_right) : SAMPLE_W'($urandom);
            send_frame(left, right);
        end
    endtask

    // single full-scale frame walked through every tap and the pass-through
    task automatic test_impulse_response();
        send_frame(SAMPLE_MAX, SAMPLE_MIN);
        repeat (PASS_DELAY + 1) send_frame(16'sd0, 16'sd0);
    endtask

    task automatic test_field_extremes();
        send_frame(SAMPLE_MAX, SAMPLE_MAX);
        send_frame(SAMPLE_MIN, SAMPLE_MIN);
        send_frame(SAMPLE_MAX, SAMPLE_MIN);
        send_frame(SAMPLE_MIN, SAMPLE_MAX);
        send_frame(-16'sd1, 16'sd1);
        send_frame(16'sd0, 16'sd0);
    endtask

    // saturation on both channels, left only, right only
    task automatic test_clip_bursts();
        send_slip_run(45, 1'b1, 1'b1, 1'b1);
        send_slip_run(45, 1'b1, 1'b0, 1'b0);
        send_slip_run(45, 1'b0, 1'b1, 1'b0);
    endtask

    task automatic test_random_mix(input int frames);
        int        done;
        int        run;
        mix_mode_t mode;
        done = 0;
        while (done < frames) begin
            run  = $urandom_range(10, 60);
            mode = mix_mode_t'($urandom_range(0, 4));
            if (mode == MIX_SLIP) begin
                send_slip_run(run, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
            end else begin
                repeat (run) begin
                    case (mode)
                        MIX_QUIET:
                            send_frame(SAMPLE_W'($urandom_range(0, 128)) - 16'sd64,
                                       SAMPLE_W'($urandom_range(0, 128)) - 16'sd64);
                        MIX_EXTREMES:
                            send_frame(extreme_value(), extreme_value());
                        MIX_SPARSE:
                            send_frame(($urandom_range(0, 15) == 0) ? SAMPLE_W'($urandom) : 16'sd0,
                                       ($urandom_range(0, 15) == 0) ? SAMPLE_W'($urandom) : 16'sd0);
                        default:
                            send_frame(SAMPLE_W'($urandom), SAMPLE_W'($urandom));
                    endcase
                end
            end
            done += run;
        end
    endtask

    // sender waits for the block to empty, then carries on
    task automatic test_drain_pause();
        test_random_mix(30);
        hold_off_until_drained();
        test_random_mix(30);
    endtask

    // no idling on either side for the last stretch
    task automatic test_back_to_back();
        idling_on = 1'b0;
        test_random_mix(150);
    endtask

    task automatic log_fault(input string what, input hsu_pkg::out_item_t want,
                             input hsu_pkg::out_item_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t %s: expected L=%0d R=%0d last=%0b clip=%0d, %s",
                     $time, what, want.left_out, want.right_out, want.is_last,
                     want.clip_total,
                     $sformatf("got L=%0d R=%0d last=%0b clip=%0d",
                               got.left_out, got.right_out, got.is_last, got.clip_total));
    endtask

    // result side: random back-pressure in bursts
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (!idling_on)
                stall_left = 0;
            else if (stall_left == 0 && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 15);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // compare each output transaction with the oldest expectation
    always @(posedge aclk) begin
        hsu_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_upsampled.size() == 0) begin
                log_fault("unexpected result", '0, m_data);
            end else begin
                want = expected_upsampled.pop_front();
                if (m_data.left_out !== want.left_out || m_data.right_out !== want.right_out ||
                    m_data.is_last !== want.is_last || m_data.clip_total !== want.clip_total)
                    log_fault("result mismatch", want, m_data);
            end
        end
    end

    // test sequence
    initial begin
        foreach (left_ring[i]) begin
            left_ring[i]  = '0;
            right_ring[i] = '0;
        end
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_impulse_response();
        test_field_extremes();
        test_clip_bursts();
        test_random_mix(600);
        test_drain_pause();
        test_random_mix(540);
        test_back_to_back();

        hold_off_until_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("run covered %0d frames and %0d output transactions, %0d clipped midpoints",
                 frames_sent, results_seen, clip_tally);
        $display("including one full drain mid-run and %0d frames with no idling", tail_frames);
        if (mismatch_count == 0 && expected_upsampled.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count,
                     expected_upsampled.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/hsu_pkg.sv
hw/rtl/hsu_history.sv
hw/rtl/hsu_mac.sv
hw/rtl/hsu_round.sv
hw/rtl/halfband_stereo_upsampler_2x.sv
dv/halfband_stereo_upsampler_2x_test.sv
